// ===== design/cla_pkg.sv =====
// shared widths, register indexes and placement state for the log space check
package cla_pkg;

  localparam int OFF_W   = 24;
  localparam int NAME_W  = 8;
  localparam int DATA_W  = 24;
  localparam int PART_W  = 25;
  localparam int SHIFT_W = 5;
  localparam int CFG_W   = 25;
  localparam int RND_W   = 26;
  localparam int POS_W   = 28;

  typedef logic [0:0] reg_idx_t;

  localparam reg_idx_t REG_PARTITION_BYTES = 1'b0;
  localparam reg_idx_t REG_SECTOR_SHIFT    = 1'b1;

  localparam logic [PART_W-1:0]  PARTITION_RESET = 25'd16777216;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET     = 5'd12;

  typedef struct packed {
    logic             ok;
    logic             wrapped;
    logic [POS_W-1:0] pos;
  } place_t;

endpackage

// ===== design/cla_req_if.sv =====
// request channel carrying one space check query
interface cla_req_if;
  logic        valid;
  logic        ready;
  logic        has_old_record;
  logic [7:0]  old_name_len;
  logic [23:0] old_data_len;
  logic [23:0] start_offset;
  logic [7:0]  new_name_len;
  logic [23:0] new_data_len;
  logic [23:0] head_offset;
  logic [23:0] tail_offset;
  logic [7:0]  largest_name_len;
  logic [23:0] largest_data_len;

  modport source (
    output valid, has_old_record, old_name_len, old_data_len, start_offset,
           new_name_len, new_data_len, head_offset, tail_offset,
           largest_name_len, largest_data_len,
    input  ready
  );

  modport sink (
    input  valid, has_old_record, old_name_len, old_data_len, start_offset,
           new_name_len, new_data_len, head_offset, tail_offset,
           largest_name_len, largest_data_len,
    output ready
  );
endinterface

// ===== design/cla_rsp_if.sv =====
// response channel carrying the no-space flag
interface cla_rsp_if;
  logic valid;
  logic ready;
  logic no_space;

  modport source (output valid, no_space, input ready);
  modport sink (input valid, no_space, output ready);
endinterface

// ===== design/cla_round.sv =====
// three-stage round-up to the alignment by reciprocal multiply and correction
module cla_round #(
  parameter int ALIGN_BYTES = 32
) (
  input  logic                      clk,
  input  logic [2:0]                en,
  input  logic [cla_pkg::RND_W-1:0] x,
  output logic [cla_pkg::RND_W-1:0] rounded
);
  import cla_pkg::*;

  localparam int PROD_W = 2 * RND_W;
  localparam logic [RND_W:0] RECIP =
    (RND_W + 1)'((64'd1 << RND_W) / ALIGN_BYTES);
  localparam logic [RND_W-1:0] ALIGN  = RND_W'(ALIGN_BYTES);
  localparam logic [RND_W-1:0] AMINUS = RND_W'(ALIGN_BYTES - 1);

  logic [RND_W-1:0]  y1;
  logic [RND_W-1:0]  y2;
  logic [RND_W-1:0]  y3;
  logic [PROD_W-1:0] prod2;
  logic [RND_W-1:0]  q2;
  logic [RND_W-1:0]  p3;
  logic [RND_W-1:0]  rem3;

  assign q2 = prod2[PROD_W-1:RND_W];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y1 <= x + AMINUS;
    end
    if (en[1]) begin
      y2    <= y1;
      prod2 <= PROD_W'(y1) * PROD_W'(RECIP);
    end
    if (en[2]) begin
      y3 <= y2;
      p3 <= q2 * ALIGN;
    end
  end

  // quotient estimate is at most one short
  always_comb begin
    rem3    = y3 - p3;
    rounded = (rem3 >= ALIGN) ? p3 + ALIGN : p3;
  end
endmodule

// ===== design/cla_place.sv =====
// one record placement with a single allowed wrap to offset zero
module cla_place #(
  parameter logic [cla_pkg::POS_W-1:0] MARKER = '0
) (
  input  cla_pkg::place_t           cur,
  input  logic [cla_pkg::POS_W-1:0] raw_pos,
  input  logic [cla_pkg::POS_W-1:0] size,
  input  logic [cla_pkg::POS_W-1:0] part,
  output cla_pkg::place_t           nxt
);
  import cla_pkg::*;

  logic [POS_W-1:0] need_end;

  always_comb begin
    need_end = raw_pos + size + MARKER;
    nxt      = cur;
    if (cur.ok) begin
      if (need_end <= part) begin
        nxt.pos = cur.pos + size;
      end else if (cur.wrapped) begin
        nxt.ok = 1'b0;
      end else begin
        nxt.wrapped = 1'b1;
        nxt.pos     = size;
      end
    end
  end
endmodule

// ===== design/circular_log_space_check.sv =====
// Space check for appending a record to a circular flash log. One query is
// accepted per clock unless the pipeline is stalled; stages stall
// independently, so a bubble lets a new query in while a result waits.
// The pipeline has three rounding stages (an offset add, a reciprocal
// multiply and a multiply back), one stage that corrects and registers the
// rounded sizes, and six stages that place the new, old and twice the largest
// record with the sector and head checks. The user must write partition_bytes
// and sector_shift only while idle; the block itself does not enforce this.
module circular_log_space_check #(
  parameter int ADDR_BITS    = 24,
  parameter int HEADER_BYTES = 8,
  parameter int ALIGN_BYTES  = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  cla_pkg::reg_idx_t         cfg_index,
  input  logic [cla_pkg::CFG_W-1:0] cfg_data,
  cla_req_if.sink                   req,
  cla_rsp_if.source                 rsp
);
  import cla_pkg::*;

  localparam int NS = 10;
  localparam logic [POS_W-1:0] MARKER =
    POS_W'(((HEADER_BYTES + 1 + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES);
  localparam logic [PART_W:0] PART_CAP = (ADDR_BITS >= PART_W) ?
    {1'b1, {PART_W{1'b0}}} : (PART_W + 1)'(64'd1 << ADDR_BITS);
  localparam logic [RND_W-1:0] HDR_TERM = RND_W'(HEADER_BYTES + 1);

  typedef struct packed {
    logic [OFF_W-1:0] wr;
    logic [OFF_W-1:0] head;
    logic             wrapped;
    logic             has_old;
  } side_t;

  logic [PART_W-1:0]  partition_bytes;
  logic [SHIFT_W-1:0] sector_shift;
  logic [PART_W-1:0]  part_eff;
  logic [POS_W-1:0]   part;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  logic [RND_W-1:0] wr_x;
  logic [RND_W-1:0] new_x;
  logic [RND_W-1:0] old_x;
  logic [RND_W-1:0] big_x;
  logic [RND_W-1:0] wr_r;
  logic [RND_W-1:0] new_r;
  logic [RND_W-1:0] old_r;
  logic [RND_W-1:0] big_r;

  side_t side0;
  side_t side1;
  side_t side2;
  side_t side3;
  logic [RND_W-1:0] w3;
  logic [RND_W-1:0] n3;
  logic [RND_W-1:0] o3;
  logic [RND_W-1:0] b3;

  logic [RND_W-1:0] old_sz;
  logic [RND_W-1:0] big_sz;
  place_t           start4;
  place_t           place4;
  place_t           place5;
  place_t           place6;
  place_t           guard7;
  place_t           place8;
  place_t           guard9;

  place_t           st4;
  place_t           st5;
  place_t           st6;
  place_t           st7;
  place_t           st8;
  logic [POS_W-1:0] old4;
  logic [POS_W-1:0] big4;
  logic [POS_W-1:0] big5;
  logic [POS_W-1:0] big6;
  logic [POS_W-1:0] big7;
  logic [OFF_W-1:0] head4;
  logic [OFF_W-1:0] head5;
  logic [OFF_W-1:0] head6;
  logic [OFF_W-1:0] head7;
  logic [OFF_W-1:0] head8;
  logic             no_space;

  function automatic place_t head_guard(place_t s, logic [OFF_W-1:0] head,
                                        logic [SHIFT_W-1:0] sh);
    place_t           r;
    logic [POS_W-1:0] h;
    r = s;
    h = POS_W'(head);
    if (s.ok && s.wrapped) begin
      if ((((s.pos ^ h) >> sh) == '0) || (s.pos >= h)) begin
        r.ok = 1'b0;
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      partition_bytes <= PARTITION_RESET;
      sector_shift    <= SHIFT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PARTITION_BYTES: partition_bytes <= cfg_data[PART_W-1:0];
        REG_SECTOR_SHIFT:    sector_shift    <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    part_eff = ({1'b0, partition_bytes} > PART_CAP) ?
               PART_CAP[PART_W-1:0] : partition_bytes;
    part     = POS_W'(part_eff);
  end

  // stall chain
  always_comb begin
    en[NS-1] = !v[NS-1] || rsp.ready;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  assign req.ready    = en[0];
  assign rsp.valid    = v[NS-1];
  assign rsp.no_space = no_space;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= req.valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  always_comb begin
    wr_x  = RND_W'(req.start_offset);
    new_x = HDR_TERM + RND_W'(req.new_name_len) + RND_W'(req.new_data_len);
    old_x = HDR_TERM + RND_W'(req.old_name_len) + RND_W'(req.old_data_len);
    big_x = HDR_TERM + RND_W'(req.largest_name_len) +
            RND_W'(req.largest_data_len);
  end

  cla_round #(.ALIGN_BYTES(ALIGN_BYTES)) u_round_wr (
    .clk(clk), .en(en[2:0]), .x(wr_x), .rounded(wr_r)
  );
  cla_round #(.ALIGN_BYTES(ALIGN_BYTES)) u_round_new (
    .clk(clk), .en(en[2:0]), .x(new_x), .rounded(new_r)
  );
  cla_round #(.ALIGN_BYTES(ALIGN_BYTES)) u_round_old (
    .clk(clk), .en(en[2:0]), .x(old_x), .rounded(old_r)
  );
  cla_round #(.ALIGN_BYTES(ALIGN_BYTES)) u_round_big (
    .clk(clk), .en(en[2:0]), .x(big_x), .rounded(big_r)
  );

  always_comb begin
    old_sz = side3.has_old ? o3 : '0;
    big_sz = b3;
    if (n3 > big_sz) begin
      big_sz = n3;
    end
    if (old_sz > big_sz) begin
      big_sz = old_sz;
    end
    start4.ok      = 1'b1;
    start4.wrapped = side3.wrapped;
    start4.pos     = POS_W'(w3);
  end

  cla_place #(.MARKER(MARKER)) u_place_new (
    .cur(start4), .raw_pos(POS_W'(side3.wr)), .size(POS_W'(n3)),
    .part(part), .nxt(place4)
  );
  cla_place #(.MARKER(MARKER)) u_place_old (
    .cur(st4), .raw_pos(st4.pos), .size(old4), .part(part), .nxt(place5)
  );
  cla_place #(.MARKER(MARKER)) u_place_big0 (
    .cur(st5), .raw_pos(st5.pos), .size(big5), .part(part), .nxt(place6)
  );
  cla_place #(.MARKER(MARKER)) u_place_big1 (
    .cur(st7), .raw_pos(st7.pos), .size(big7), .part(part), .nxt(place8)
  );

  always_comb begin
    guard7 = head_guard(st6, head6, sector_shift);
    guard9 = head_guard(st8, head8, sector_shift);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side0.wr      <= req.start_offset;
      side0.head    <= req.head_offset;
      side0.wrapped <= req.head_offset >= req.tail_offset;
      side0.has_old <= req.has_old_record;
    end
    if (en[1]) begin
      side1 <= side0;
    end
    if (en[2]) begin
      side2 <= side1;
    end
    if (en[3]) begin
      side3 <= side2;
      w3    <= wr_r;
      n3    <= new_r;
      o3    <= old_r;
      b3    <= big_r;
    end
    if (en[4]) begin
      st4   <= place4;
      old4  <= POS_W'(old_sz);
      big4  <= POS_W'(big_sz);
      head4 <= side3.head;
    end
    if (en[5]) begin
      st5   <= place5;
      big5  <= big4;
      head5 <= head4;
    end
    if (en[6]) begin
      st6   <= place6;
      big6  <= big5;
      head6 <= head5;
    end
    if (en[7]) begin
      st7   <= guard7;
      big7  <= big6;
      head7 <= head6;
    end
    if (en[8]) begin
      st8   <= place8;
      head8 <= head7;
    end
    if (en[9]) begin
      no_space <= !guard9.ok;
    end
  end

  a_full_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (&v) && !rsp.ready |-> !req.ready)
    else $error("input taken while every stage holds a stalled beat");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> v[0])
    else $error("accepted beat missing from first stage");

  a_fail_sticks: assert property (@(posedge clk) disable iff (rst)
    v[4] && en[5] && !st4.ok |=> !st5.ok)
    else $error("failed placement recovered in later stage");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp.valid)
    else $error("response valid right after reset");
endmodule

// ===== tb/tb.sv =====
// testbench for circular_log_space_check: directed and random space queries checked in order
`timescale 1ns / 1ps

module tb;
  import cla_pkg::*;

  localparam int ADDR_BITS       = 24;
  localparam int HEADER_BYTES    = 8;
  localparam int ALIGN_BYTES     = 32;
  localparam int PIPE_LATENCY    = 10;
  localparam int SETTLE_CYCLES   = 2 * PIPE_LATENCY + 4;
  localparam int WATCHDOG_CYCLES = 2000;

  typedef struct {
    bit        has_old;
    bit [7:0]  old_name;
    bit [23:0] old_data;
    bit [23:0] wr_off;
    bit [7:0]  new_name;
    bit [23:0] new_data;
    bit [23:0] head;
    bit [23:0] tail;
    bit [7:0]  big_name;
    bit [23:0] big_data;
  } space_query_t;

  class space_board;
    bit [PART_W-1:0]  part_reg;
    bit [SHIFT_W-1:0] shift_reg;
    bit               want_no_space_q[$];
    int               errors;

    function new();
      part_reg  = PARTITION_RESET;
      shift_reg = SHIFT_RESET;
      errors    = 0;
    endfunction

    function longint unsigned round_to_align(longint unsigned x);
      return (x + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
    endfunction

    function longint unsigned record_bytes(longint unsigned name_len,
                                           longint unsigned payload_len);
      return round_to_align(HEADER_BYTES + name_len + 1 + payload_len);
    endfunction

    function bit place_record(inout longint unsigned pos, inout bit wrapped,
                              input longint unsigned size, input longint unsigned marker,
                              input longint unsigned part);
      if (pos + size + marker > part) begin
        if (wrapped) return 1'b0;
        wrapped = 1'b1;
        pos     = 0;
      end
      pos = round_to_align(pos + size);
      return 1'b1;
    endfunction

    function bit predict_no_space(space_query_t q);
      longint unsigned part, old_sz, new_sz, big_sz, marker, pos;
      bit wrapped, ok;
      part = part_reg;
      if (part > (64'd1 << ADDR_BITS)) part = 64'd1 << ADDR_BITS;
      old_sz  = q.has_old ? record_bytes(q.old_name, q.old_data) : 0;
      new_sz  = record_bytes(q.new_name, q.new_data);
      marker  = round_to_align(HEADER_BYTES + 1);
      big_sz  = record_bytes(q.big_name, q.big_data);
      if (new_sz > big_sz) big_sz = new_sz;
      if (old_sz > big_sz) big_sz = old_sz;
      wrapped = q.head >= q.tail;
      pos     = q.wr_off;
      ok = place_record(pos, wrapped, new_sz, marker, part);
      if (ok) ok = place_record(pos, wrapped, old_sz, marker, part);
      for (int i = 0; i < 2; i++) begin
        if (ok) begin
          if (!place_record(pos, wrapped, big_sz, marker, part)) ok = 1'b0;
          else if (wrapped && (pos >> shift_reg) == (64'(q.head) >> shift_reg)) ok = 1'b0;
          else if (wrapped && pos >= q.head) ok = 1'b0;
        end
      end
      return !ok;
    endfunction

    function void note_query(space_query_t q);
      want_no_space_q.push_back(predict_no_space(q));
    endfunction

    function void check_flag(logic got);
      bit want;
      if (want_no_space_q.size() == 0) begin
        if (errors < 10) $display("unexpected result beat: no_space=%0b", got);
        errors++;
      end else begin
        want = want_no_space_q.pop_front();
        if (got !== want) begin
          if (errors < 10) $display("no_space mismatch: expected %0b got %0b", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            cfg_wr_en;
  reg_idx_t        cfg_index;
  logic [CFG_W-1:0] cfg_data;

  cla_req_if req_ch ();
  cla_rsp_if rsp_ch ();

  circular_log_space_check #(
    .ADDR_BITS(ADDR_BITS),
    .HEADER_BYTES(HEADER_BYTES),
    .ALIGN_BYTES(ALIGN_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  space_board board = new();
  bit quiet = 1'b0;
  int rsp_stall_left = 0;
  int rsp_run_left = 0;
  int send_run_left = 0;
  int idle_cycles = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(negedge clk) begin
    if (quiet) begin
      rsp_ch.ready <= 1'b1;
    end else if (rsp_stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall_left--;
    end else if (rsp_run_left > 0) begin
      rsp_ch.ready <= 1'b1;
      rsp_run_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall_left = $urandom_range(1, 7) - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      rsp_run_left = $urandom_range(1, 30) - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) board.check_flag(rsp_ch.no_space);
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic space_query_t mk_query(int unsigned has_old, int unsigned old_name,
                                            int unsigned old_data, int unsigned wr_off,
                                            int unsigned new_name, int unsigned new_data,
                                            int unsigned head, int unsigned tail,
                                            int unsigned big_name, int unsigned big_data);
    space_query_t q;
    q.has_old  = has_old[0];
    q.old_name = old_name[7:0];
    q.old_data = old_data[23:0];
    q.wr_off   = wr_off[23:0];
    q.new_name = new_name[7:0];
    q.new_data = new_data[23:0];
    q.head     = head[23:0];
    q.tail     = tail[23:0];
    q.big_name = big_name[7:0];
    q.big_data = big_data[23:0];
    return q;
  endfunction

  function automatic space_query_t random_query(longint unsigned part);
    space_query_t q;
    longint unsigned span, lim;
    int unsigned mode;
    span = (part > (64'd1 << ADDR_BITS)) ? (64'd1 << ADDR_BITS) : part;
    if (span < 256) span = 256;
    mode       = $urandom_range(0, 9);
    q.has_old  = 1'($urandom_range(0, 1));
    q.old_name = 8'($urandom);
    q.new_name = 8'($urandom);
    q.big_name = 8'($urandom);
    if (mode == 0) begin
      q.old_data = 24'($urandom);
      q.wr_off   = 24'($urandom);
      q.new_data = 24'($urandom);
      q.head     = 24'($urandom);
      q.tail     = 24'($urandom);
      q.big_data = 24'($urandom);
    end else begin
      lim = span >> $urandom_range(3, 10);
      q.old_data = 24'($urandom_range(0, 32'(lim)));
      q.new_data = 24'($urandom_range(0, 32'(lim)));
      q.big_data = 24'($urandom_range(0, 32'(lim)));
      if (mode == 1) q.big_data = 24'($urandom_range(0, 32'(span - 1)));
      q.head = 24'($urandom_range(0, 32'(span - 1)));
      q.tail = 24'($urandom_range(0, 32'(span - 1)));
      case ($urandom_range(0, 4))
        0: q.wr_off = q.tail;
        1: q.wr_off = q.tail & ~24'(ALIGN_BYTES - 1);
        2: q.wr_off = 24'($urandom_range(0, 32'(span - 1)));
        3: q.wr_off = 24'(32'(span) - $urandom_range(0, 32'(lim) + 64));
        default: q.wr_off = 24'($urandom);
      endcase
      if (mode == 2) begin
        q.head = q.head & ~24'(ALIGN_BYTES - 1);
        q.tail = q.tail & ~24'(ALIGN_BYTES - 1);
      end
    end
    return q;
  endfunction

  task automatic send_query(space_query_t q);
    req_ch.valid            <= 1'b1;
    req_ch.has_old_record   <= q.has_old;
    req_ch.old_name_len     <= q.old_name;
    req_ch.old_data_len     <= q.old_data;
    req_ch.start_offset     <= q.wr_off;
    req_ch.new_name_len     <= q.new_name;
    req_ch.new_data_len     <= q.new_data;
    req_ch.head_offset      <= q.head;
    req_ch.tail_offset      <= q.tail;
    req_ch.largest_name_len <= q.big_name;
    req_ch.largest_data_len <= q.big_data;
    do @(posedge clk); while (!req_ch.ready);
    board.note_query(q);
    @(negedge clk);
  endtask

  task automatic sender_pause();
    if (!quiet) begin
      if (send_run_left > 0) begin
        send_run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        send_run_left = $urandom_range(1, 30);
      end
    end
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (board.want_no_space_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(bit [PART_W-1:0] part, bit [SHIFT_W-1:0] shift);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_PARTITION_BYTES;
    cfg_data  <= CFG_W'(part);
    @(negedge clk);
    cfg_index <= REG_SECTOR_SHIFT;
    cfg_data  <= CFG_W'(shift);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.part_reg  = part;
    board.shift_reg = shift;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      send_query(random_query(board.part_reg));
      sender_pause();
    end
  endtask

  task automatic run_directed(space_query_t list[$]);
    foreach (list[i]) begin
      send_query(list[i]);
      sender_pause();
    end
  endtask

  initial begin
    space_query_t dir_q[$];
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_index    = REG_PARTITION_BYTES;
    cfg_data     = '0;
    rsp_ch.ready = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.has_old_record   = 1'b0;
    req_ch.old_name_len     = '0;
    req_ch.old_data_len     = '0;
    req_ch.start_offset     = '0;
    req_ch.new_name_len     = '0;
    req_ch.new_data_len     = '0;
    req_ch.head_offset      = '0;
    req_ch.tail_offset      = '0;
    req_ch.largest_name_len = '0;
    req_ch.largest_data_len = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default partition and sector size
    dir_q = {};
    dir_q.push_back(mk_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_query(1, 255, 24'hFFFFFF, 24'hFFFFFF, 255, 24'hFFFFFF,
                             24'hFFFFFF, 24'hFFFFFF, 255, 24'hFFFFFF));
    dir_q.push_back(mk_query(0, 255, 24'hFFFFFF, 24'h010000, 10, 100,
                             24'h100000, 24'h010000, 20, 200));
    dir_q.push_back(mk_query(1, 255, 24'hFFFFFF, 24'h010000, 10, 100,
                             24'h100000, 24'h010000, 20, 200));
    dir_q.push_back(mk_query(1, 3, 40, 24'h010000, 10, 100,
                             24'h100000, 24'h010000, 20, 200));
    dir_q.push_back(mk_query(0, 0, 0, 24'hFFFFE0, 5, 50, 24'h001000, 24'h800000, 5, 50));
    dir_q.push_back(mk_query(0, 0, 0, 24'hFFFFE0, 5, 50, 24'h800000, 24'h001000, 5, 50));
    dir_q.push_back(mk_query(0, 0, 0, 24'h001000, 1, 1, 24'h001100, 24'h001000, 1, 1));
    dir_q.push_back(mk_query(0, 0, 0, 24'h001FE0, 1, 1, 24'h001FF0, 24'h001000, 1, 1));
    dir_q.push_back(mk_query(0, 0, 0, 24'hFFFFC0, 0, 0, 24'h003000, 24'h004000, 0, 0));
    dir_q.push_back(mk_query(0, 0, 0, 24'hFFFFC0, 0, 0, 24'h004000, 24'h003000, 0, 0));
    dir_q.push_back(mk_query(0, 0, 0, 24'h000000, 255, 5000, 24'h400000, 24'h000000, 0, 0));
    dir_q.push_back(mk_query(1, 255, 0, 24'h000000, 0, 0, 24'h400000, 24'h000000, 255, 0));
    dir_q.push_back(mk_query(1, 8'hAA, 24'hAAAAAA, 24'hAAAAAA, 8'hAA, 24'hAAAAAA,
                             24'hAAAAAA, 24'h555555, 8'hAA, 24'hAAAAAA));
    dir_q.push_back(mk_query(0, 8'h55, 24'h555555, 24'h555555, 8'h55, 24'h555555,
                             24'h555555, 24'hAAAAAA, 8'h55, 24'h555555));
    run_directed(dir_q);
    run_random(80);
    wait_idle();
    run_random(80);

    // small partition: offsets past the end
    configure(25'd4096, 5'd8);
    dir_q = {};
    dir_q.push_back(mk_query(0, 0, 0, 5000, 1, 1, 1000, 2000, 1, 1));
    dir_q.push_back(mk_query(0, 0, 0, 5000, 1, 1, 2000, 1000, 1, 1));
    dir_q.push_back(mk_query(1, 2, 20, 24'hFFFFFF, 0, 0, 3000, 3500, 0, 0));
    run_directed(dir_q);
    run_random(100);

    configure(25'd0, 5'd12);
    run_random(40);
    configure(25'h1FFFFFF, 5'd31);
    run_random(100);
    configure(25'd1, 5'd0);
    run_random(40);
    configure(25'd65536, 5'd20);
    run_random(100);
    configure(25'd1000003, 5'd13);
    run_random(100);
    repeat (2) begin
      configure(PART_W'($urandom_range(1024, 32'h1000000)), SHIFT_W'($urandom_range(8, 20)));
      run_random(100);
    end

    configure(PARTITION_RESET, SHIFT_RESET);
    quiet = 1'b1;
    run_random(120);
    req_ch.valid <= 1'b0;
    while (board.want_no_space_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (board.errors == 0 && board.want_no_space_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== circular_log_space_check.f =====
design/cla_pkg.sv
design/cla_req_if.sv
design/cla_rsp_if.sv
design/cla_round.sv
design/cla_place.sv
design/circular_log_space_check.sv
tb/tb.sv
